>>> rtl/pai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_pkg
// Shared types, codes and reset values of the pressure angle interpolator.
// ----------------------------------------------------------------------------
package pai_pkg;

	localparam int PRESSURE_DEPTH_DEF = 1024;
	localparam int ANGLE_DEPTH_DEF    = 1024;
	localparam int CFG_AW             = 4;

	localparam logic [30:0] OVERLAP_RST   = 31'd65536;
	localparam logic [10:0] MIN_P_CNT_RST = 11'd3;
	localparam logic [10:0] MIN_A_CNT_RST = 11'd6;

	localparam logic [1:0] REG_OVERLAP   = 2'd0;
	localparam logic [1:0] REG_MIN_P_CNT = 2'd1;
	localparam logic [1:0] REG_MIN_A_CNT = 2'd2;

	localparam logic [1:0] REQ_LOAD_P  = 2'd0;
	localparam logic [1:0] REQ_LOAD_A  = 2'd1;
	localparam logic [1:0] REQ_COMPUTE = 2'd2;
	localparam logic [1:0] REQ_CLEAR   = 2'd3;

	localparam logic [3:0] STS_OK        = 4'd0;
	localparam logic [3:0] STS_EMPTY     = 4'd1;
	localparam logic [3:0] STS_NO_PSTART = 4'd2;
	localparam logic [3:0] STS_NO_PEND   = 4'd3;
	localparam logic [3:0] STS_FEW_P     = 4'd4;
	localparam logic [3:0] STS_NO_ASTART = 4'd5;
	localparam logic [3:0] STS_NO_AEND   = 4'd6;
	localparam logic [3:0] STS_FEW_A     = 4'd7;
	localparam logic [3:0] STS_NO_PCROSS = 4'd8;
	localparam logic [3:0] STS_ZERO_DP   = 4'd9;
	localparam logic [3:0] STS_NO_ACROSS = 4'd10;
	localparam logic [3:0] STS_ZERO_DT   = 4'd11;

	typedef struct packed {
		logic        [1:0]  req_type;
		logic        [31:0] sample_time;
		logic signed [31:0] sample_value;
		logic signed [31:0] target_pressure;
	} req_t;

	typedef struct packed {
		logic        [3:0]  status;
		logic signed [31:0] angle;
		logic               store_overflowed;
	} res_t;

endpackage

>>> rtl/pai_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pai_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module pai_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/pressure_angle_interpolator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pressure_angle_interpolator_top
// Timed pressure and angle sample stores with window search and two-step
// interpolation of the angle at a target pressure.
//
// Channel   Signals                                  Transfer
// request   start, busy, req                         start high, busy low
// result    result_valid, result                     result_valid high
// config    psel, penable, pwrite, paddr, pwdata,    psel, penable, pwrite high
//           prdata, pready
//
// Loads and clears are handled in the idle state. A compute visits samples in
// each of the four window scans and the two crossing scans, and uses the
// shared restoring divider for each of its two divisions and the shared
// multiplier for each of its two products.
// Reset clears the counts and the overflow flag and returns the registers to
// their defaults; the stores keep their contents. The result strobe lasts one
// cycle and cannot be held.
// ----------------------------------------------------------------------------
module pressure_angle_interpolator_top import pai_pkg::*; #(
	parameter int PRESSURE_DEPTH = PRESSURE_DEPTH_DEF,
	parameter int ANGLE_DEPTH    = ANGLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              result_valid,
	output res_t              result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int PAW = $clog2(PRESSURE_DEPTH);
	localparam int PCW = $clog2(PRESSURE_DEPTH + 1);
	localparam int AAW = $clog2(ANGLE_DEPTH);
	localparam int ACW = $clog2(ANGLE_DEPTH + 1);
	localparam int DVW = 50;
	localparam int TQW = 51;

	typedef enum logic [16:0] {
		ST_IDLE   = 17'h00001,
		ST_PF_RD  = 17'h00002,
		ST_PF_CHK = 17'h00004,
		ST_PT_RD  = 17'h00008,
		ST_PT_CHK = 17'h00010,
		ST_AF_RD  = 17'h00020,
		ST_AF_CHK = 17'h00040,
		ST_AT_RD  = 17'h00080,
		ST_AT_CHK = 17'h00100,
		ST_PX_RD  = 17'h00200,
		ST_PX_CHK = 17'h00400,
		ST_DIV    = 17'h00800,
		ST_MUL    = 17'h01000,
		ST_TQ     = 17'h02000,
		ST_AX_RD  = 17'h04000,
		ST_AX_CHK = 17'h08000,
		ST_ANG    = 17'h10000
	} state_t;

	state_t state_q;

	logic [30:0]  overlap_q;
	logic [10:0]  min_p_q;
	logic [10:0]  min_a_q;
	logic [PCW-1:0] pcnt_q, pi_q, pf_q, pt_q;
	logic [ACW-1:0] acnt_q, ai_q, af_q, at_q, bgn_q;
	logic         ovf_q;

	logic signed [31:0] tgt_q;
	logic signed [33:0] lo_q, hi_q;
	logic [31:0]  tfrom_q, tto_q;
	logic [31:0]  prv_t_q;
	logic signed [31:0] prv_v_q;
	logic [DVW-1:0] dv_r_q, dv_d_q;
	logic [30:0]  dv_q_q;
	logic [4:0]   dv_cnt_q;
	logic [31:0]  mul_b_q;
	logic         mul_neg_q;
	logic         phase_b_q;
	logic [62:0]  prod_q;
	logic [TQW-1:0] tq_q;
	logic [3:0]   res_status_q;
	logic signed [31:0] res_angle_q;
	logic         res_ovf_q;
	logic         res_valid_q;

	logic         acc;
	logic         cfg_wr;
	logic [1:0]   cfg_idx;
	logic         p_we, a_we;
	logic [63:0]  p_rd, a_rd;
	logic [31:0]  p_tim, a_tim;
	logic signed [31:0] p_val, a_val;

	assign acc     = start && !busy;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];
	assign pready  = 1'b1;
	assign p_we    = acc && req.req_type == REQ_LOAD_P && pcnt_q != PCW'(PRESSURE_DEPTH);
	assign a_we    = acc && req.req_type == REQ_LOAD_A && acnt_q != ACW'(ANGLE_DEPTH);

	pai_ram #(.WIDTH(64), .DEPTH(PRESSURE_DEPTH)) u_pram (
		.clk   (clk),
		.we    (p_we),
		.waddr (pcnt_q[PAW-1:0]),
		.wdata ({req.sample_time, req.sample_value}),
		.raddr (pi_q[PAW-1:0]),
		.rdata (p_rd)
	);

	pai_ram #(.WIDTH(64), .DEPTH(ANGLE_DEPTH)) u_aram (
		.clk   (clk),
		.we    (a_we),
		.waddr (acnt_q[AAW-1:0]),
		.wdata ({req.sample_time, req.sample_value}),
		.raddr (ai_q[AAW-1:0]),
		.rdata (a_rd)
	);

	assign p_tim = p_rd[63:32];
	assign p_val = p_rd[31:0];
	assign a_tim = a_rd[63:32];
	assign a_val = a_rd[31:0];

	always_comb begin
		unique case (cfg_idx)
			REG_OVERLAP:   prdata = {1'b0, overlap_q};
			REG_MIN_P_CNT: prdata = {21'b0, min_p_q};
			REG_MIN_A_CNT: prdata = {21'b0, min_a_q};
			default:       prdata = 32'b0;
		endcase
	end

	// Datapath terms of the scans, divider and interpolation steps.
	logic signed [33:0] p_val_x;
	logic [PCW-1:0] p_span;
	logic [ACW-1:0] a_span;
	logic         px_hit, ax_hit;
	logic signed [32:0] dp, num, dt, dtm, vdiff;
	logic [32:0]  dp_mag, num_mag, dt_mag, dtm_mag, vd_mag;
	logic signed [TQW-1:0] ta, tb, tq_s;
	logic signed [51:0] nn;
	logic [51:0]  nn_mag;
	logic [DVW-1:0] dv_sh;
	logic         dv_ge;
	logic [TQW-1:0] tq_add;
	logic signed [33:0] ang_sum;
	logic [33:0]  ang_sh;

	always_comb begin
		p_val_x = {{2{p_val[31]}}, p_val};
		p_span  = pi_q - pf_q;
		a_span  = ai_q - af_q;
		px_hit  = (prv_v_q <= tgt_q && tgt_q <= p_val) || (p_val <= tgt_q && tgt_q <= prv_v_q);
		dp      = {p_val[31], p_val} - {prv_v_q[31], prv_v_q};
		num     = {tgt_q[31], tgt_q} - {prv_v_q[31], prv_v_q};
		dt      = {1'b0, p_tim} - {1'b0, prv_t_q};
		dp_mag  = dp[32] ? 33'(-dp) : 33'(dp);
		num_mag = num[32] ? 33'(-num) : 33'(num);
		dt_mag  = dt[32] ? 33'(-dt) : 33'(dt);
		tq_s    = tq_q;
		ta      = {3'b0, prv_t_q, 16'b0};
		tb      = {3'b0, a_tim, 16'b0};
		ax_hit  = (ta <= tq_s && tq_s <= tb) || (tb <= tq_s && tq_s <= ta);
		dtm     = {1'b0, a_tim} - {1'b0, prv_t_q};
		dtm_mag = dtm[32] ? 33'(-dtm) : 33'(dtm);
		nn      = {tq_s[TQW-1], tq_s} - {ta[TQW-1], ta};
		nn_mag  = nn[51] ? 52'(-nn) : 52'(nn);
		vdiff   = {a_val[31], a_val} - {prv_v_q[31], prv_v_q};
		vd_mag  = vdiff[32] ? 33'(-vdiff) : 33'(vdiff);
		dv_sh   = (dv_cnt_q == 5'd0) ? dv_r_q : {dv_r_q[DVW-2:0], 1'b0};
		dv_ge   = dv_sh >= dv_d_q;
		tq_add  = mul_neg_q ? TQW'(-{2'b0, prod_q[62:14]}) : {2'b0, prod_q[62:14]};
		ang_sh  = {1'b0, prod_q[62:30]};
		ang_sum = {{2{prv_v_q[31]}}, prv_v_q} + (mul_neg_q ? 34'(-ang_sh) : ang_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			overlap_q    <= OVERLAP_RST;
			min_p_q      <= MIN_P_CNT_RST;
			min_a_q      <= MIN_A_CNT_RST;
			pcnt_q       <= '0;
			acnt_q       <= '0;
			ovf_q        <= 1'b0;
			pi_q         <= '0;
			ai_q         <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_OVERLAP:   overlap_q <= pwdata[30:0];
					REG_MIN_P_CNT: min_p_q   <= pwdata[10:0];
					REG_MIN_A_CNT: min_a_q   <= pwdata[10:0];
					default:       ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (req.req_type)
							REQ_LOAD_P: begin
								if (p_we) pcnt_q <= pcnt_q + PCW'(1);
								else ovf_q <= 1'b1;
							end
							REQ_LOAD_A: begin
								if (a_we) acnt_q <= acnt_q + ACW'(1);
								else ovf_q <= 1'b1;
							end
							REQ_CLEAR: begin
								pcnt_q <= '0;
								acnt_q <= '0;
								ovf_q  <= 1'b0;
							end
							default: begin
								tgt_q       <= req.target_pressure;
								lo_q        <= {{2{req.target_pressure[31]}}, req.target_pressure}
								               - {3'b0, overlap_q};
								hi_q        <= {{2{req.target_pressure[31]}}, req.target_pressure}
								               + {3'b0, overlap_q};
								res_ovf_q   <= ovf_q;
								res_angle_q <= '0;
								pi_q        <= '0;
								ai_q        <= '0;
								if (pcnt_q == '0 || acnt_q == '0) begin
									res_status_q <= STS_EMPTY;
									res_valid_q  <= 1'b1;
								end else begin
									state_q <= ST_PF_RD;
								end
							end
						endcase
					end
				end
				ST_PF_RD: state_q <= ST_PF_CHK;
				ST_PF_CHK: begin
					if (p_val_x > lo_q) begin
						pf_q    <= pi_q;
						tfrom_q <= p_tim;
						state_q <= ST_PT_CHK;
					end else if (pi_q + PCW'(1) == pcnt_q) begin
						res_status_q <= STS_NO_PSTART;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						pi_q    <= pi_q + PCW'(1);
						state_q <= ST_PF_RD;
					end
				end
				ST_PT_RD: state_q <= ST_PT_CHK;
				ST_PT_CHK: begin
					if (p_val_x > hi_q) begin
						pt_q  <= pi_q;
						tto_q <= p_tim;
						if (32'(p_span) < 32'(min_p_q)) begin
							res_status_q <= STS_FEW_P;
							res_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							state_q <= ST_AF_RD;
						end
					end else if (pi_q + PCW'(1) == pcnt_q) begin
						res_status_q <= STS_NO_PEND;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						pi_q    <= pi_q + PCW'(1);
						state_q <= ST_PT_RD;
					end
				end
				ST_AF_RD: state_q <= ST_AF_CHK;
				ST_AF_CHK: begin
					if (a_tim > tfrom_q) begin
						af_q    <= ai_q;
						bgn_q   <= (ai_q == '0) ? ai_q : ai_q - ACW'(1);
						state_q <= ST_AT_CHK;
					end else if (ai_q + ACW'(1) == acnt_q) begin
						res_status_q <= STS_NO_ASTART;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						ai_q    <= ai_q + ACW'(1);
						state_q <= ST_AF_RD;
					end
				end
				ST_AT_RD: state_q <= ST_AT_CHK;
				ST_AT_CHK: begin
					if (a_tim > tto_q) begin
						at_q <= ai_q;
						if (32'(a_span) < 32'(min_a_q)) begin
							res_status_q <= STS_FEW_A;
							res_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else if (pt_q <= pf_q + PCW'(1)) begin
							res_status_q <= STS_NO_PCROSS;
							res_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							pi_q    <= pf_q;
							state_q <= ST_PX_RD;
						end
					end else if (ai_q + ACW'(1) == acnt_q) begin
						res_status_q <= STS_NO_AEND;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						ai_q    <= ai_q + ACW'(1);
						state_q <= ST_AT_RD;
					end
				end
				ST_PX_RD: state_q <= ST_PX_CHK;
				ST_PX_CHK: begin
					if (pi_q == pf_q) begin
						prv_t_q <= p_tim;
						prv_v_q <= p_val;
						pi_q    <= pi_q + PCW'(1);
						state_q <= ST_PX_RD;
					end else if (px_hit) begin
						if (dp == '0) begin
							res_status_q <= STS_ZERO_DP;
							res_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							dv_r_q    <= DVW'(num_mag);
							dv_d_q    <= DVW'(dp_mag);
							dv_q_q    <= '0;
							dv_cnt_q  <= '0;
							mul_b_q   <= dt_mag[31:0];
							mul_neg_q <= dt[32];
							phase_b_q <= 1'b0;
							state_q   <= ST_DIV;
						end
					end else if (pi_q + PCW'(1) == pt_q) begin
						res_status_q <= STS_NO_PCROSS;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						prv_t_q <= p_tim;
						prv_v_q <= p_val;
						pi_q    <= pi_q + PCW'(1);
						state_q <= ST_PX_RD;
					end
				end
				ST_DIV: begin
					dv_r_q   <= dv_ge ? dv_sh - dv_d_q : dv_sh;
					dv_q_q   <= {dv_q_q[29:0], dv_ge};
					dv_cnt_q <= dv_cnt_q + 5'd1;
					if (dv_cnt_q == 5'd30) state_q <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= 63'(dv_q_q) * 63'(mul_b_q);
					state_q <= phase_b_q ? ST_ANG : ST_TQ;
				end
				ST_TQ: begin
					tq_q <= {3'b0, prv_t_q, 16'b0} + tq_add;
					ai_q <= bgn_q;
					if (at_q <= bgn_q + ACW'(1)) begin
						res_status_q <= STS_NO_ACROSS;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						state_q <= ST_AX_RD;
					end
				end
				ST_AX_RD: state_q <= ST_AX_CHK;
				ST_AX_CHK: begin
					if (ai_q == bgn_q) begin
						prv_t_q <= a_tim;
						prv_v_q <= a_val;
						ai_q    <= ai_q + ACW'(1);
						state_q <= ST_AX_RD;
					end else if (ax_hit) begin
						if (dtm == '0) begin
							res_status_q <= STS_ZERO_DT;
							res_valid_q  <= 1'b1;
							state_q      <= ST_IDLE;
						end else begin
							dv_r_q    <= nn_mag[DVW-1:0];
							dv_d_q    <= DVW'({dtm_mag, 16'b0});
							dv_q_q    <= '0;
							dv_cnt_q  <= '0;
							mul_b_q   <= vd_mag[31:0];
							mul_neg_q <= vdiff[32];
							phase_b_q <= 1'b1;
							state_q   <= ST_DIV;
						end
					end else if (ai_q + ACW'(1) == at_q) begin
						res_status_q <= STS_NO_ACROSS;
						res_valid_q  <= 1'b1;
						state_q      <= ST_IDLE;
					end else begin
						prv_t_q <= a_tim;
						prv_v_q <= a_val;
						ai_q    <= ai_q + ACW'(1);
						state_q <= ST_AX_RD;
					end
				end
				ST_ANG: begin
					if (ang_sum > 34'sh0_7FFF_FFFF) res_angle_q <= 32'h7FFF_FFFF;
					else if (ang_sum < -34'sh0_8000_0000) res_angle_q <= 32'h8000_0000;
					else res_angle_q <= ang_sum[31:0];
					res_status_q <= STS_OK;
					res_valid_q  <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy                    = state_q != ST_IDLE;
	assign result_valid            = res_valid_q;
	assign result.status           = res_status_q;
	assign result.angle            = res_angle_q;
	assign result.store_overflowed = res_ovf_q;

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result strobe while the sequencer is busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != STS_OK |-> result.angle == 0)
		else $error("failing status with nonzero angle");

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pcnt_q) <= PRESSURE_DEPTH && 32'(acnt_q) <= ANGLE_DEPTH)
		else $error("store count beyond depth");

	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.req_type == REQ_COMPUTE && pcnt_q != '0 && acnt_q != '0 |=> busy)
		else $error("compute transfer did not start the sequencer");

endmodule
